>>> hdl/aacpcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aacpcp_pkg: shared types and codes of the program config parser
// Result layout, controller command and datapath status bundles, field codes.
// ----------------------------------------------------------------------------
package aacpcp_pkg;

	// field codes of a result
	localparam logic [4:0] FC_TAG    = 5'd0;
	localparam logic [4:0] FC_OBJ    = 5'd1;
	localparam logic [4:0] FC_SFI    = 5'd2;
	localparam logic [4:0] FC_NFRONT = 5'd3;
	localparam logic [4:0] FC_NSIDE  = 5'd4;
	localparam logic [4:0] FC_NBACK  = 5'd5;
	localparam logic [4:0] FC_NLFE   = 5'd6;
	localparam logic [4:0] FC_NASSOC = 5'd7;
	localparam logic [4:0] FC_NCC    = 5'd8;
	localparam logic [4:0] FC_MONO   = 5'd9;
	localparam logic [4:0] FC_STEREO = 5'd10;
	localparam logic [4:0] FC_MATRIX = 5'd11;
	localparam logic [4:0] FC_LFRONT = 5'd12;
	localparam logic [4:0] FC_CLEN   = 5'd18;
	localparam logic [4:0] FC_DONE   = 5'd19;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_PROFILE = 2'd1;
	localparam logic [1:0] ST_FREQ    = 2'd2;

	// configuration register indexes
	localparam logic CFG_PROFILE  = 1'b0;
	localparam logic CFG_FREQ_CNT = 1'b1;

	// element lists, in stream order
	localparam int          LIST_CNT  = 6;
	localparam logic [2:0]  LST_FRONT = 3'd0;
	localparam logic [2:0]  LST_SIDE  = 3'd1;
	localparam logic [2:0]  LST_BACK  = 3'd2;
	localparam logic [2:0]  LST_LFE   = 3'd3;
	localparam logic [2:0]  LST_ASSOC = 3'd4;
	localparam logic [2:0]  LST_CC    = 3'd5;

	// one result item
	typedef struct packed {
		logic [4:0] code;
		logic [3:0] index;
		logic [7:0] value;
		logic       pair;
		logic [1:0] status;
		logic       last;
	} res_t;

	// controller to datapath
	typedef struct packed {
		logic       load;        // take the accepted byte
		logic       use_offset;  // first byte of an element: skip leading bits
		logic       clear;       // new element: clear field and list state
		logic       step;        // shift one stream bit into the collector
		logic [3:0] width;       // width of the field being collected
		logic       drop;        // discard the rest of the byte
		logic       count_wr;
		logic [2:0] count_sel;
		logic [2:0] list_sel;
		logic       list_adv;
		logic       list_clr;
		logic       comment_ld;
		logic       comment_dec;
		logic       emit;
		res_t       res;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic       bit_avail;    // bits of the current byte remain
		logic       field_done;   // the next bit completes the field
		logic [7:0] value;        // field value including the next bit
		logic       prof_ok;
		logic       sfi_ok;
		logic [5:0] count_nz;
		logic       list_end;
		logic [3:0] list_pos;
		logic       comment_last;
		logic       out_free;     // output register can take a result
	} sts_t;

endpackage

>>> hdl/aacpcp_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aacpcp_dpath: bit collector and storage of the program config parser
// Byte shifter, field collector, element counts, list position, comment
// counter, configuration registers and the output register.
// ----------------------------------------------------------------------------
module aacpcp_dpath (
	input  logic               clk,
	input  logic               arst_n,
	input  aacpcp_pkg::cmd_t   cmd,
	output aacpcp_pkg::sts_t   sts,
	input  logic [7:0]         data_byte,
	input  logic [2:0]         start_bit_offset,
	input  logic               cfg_wr_en,
	input  logic               cfg_index,
	input  logic [4:0]         cfg_data,
	output logic               out_valid,
	input  logic               out_stall,
	output aacpcp_pkg::res_t   out_res
);
	import aacpcp_pkg::*;

	logic [7:0] byte_q;
	logic [3:0] bits_left_q;
	logic [7:0] coll_q;
	logic [3:0] pend_q;
	logic [3:0] counts_q [LIST_CNT];
	logic [3:0] list_pos_q;
	logic [7:0] comment_q;
	logic [1:0] prof_q;
	logic [4:0] vfic_q;
	logic       out_valid_q;
	res_t       res_q;

	logic [7:0] coll_next;
	logic [3:0] pend_next;

	// next collector value with the current stream bit
	assign coll_next = {coll_q[6:0], byte_q[7]};
	assign pend_next = 4'(pend_q + 4'd1);

	// status toward the controller
	always_comb begin
		sts.bit_avail    = (bits_left_q != 4'd0);
		sts.field_done   = (pend_next == cmd.width);
		sts.value        = coll_next;
		sts.prof_ok      = (coll_next == {6'd0, prof_q});
		sts.sfi_ok       = (coll_next < {3'd0, vfic_q});
		for (int i = 0; i < LIST_CNT; i++) begin
			sts.count_nz[i] = (counts_q[i] != 4'd0);
		end
		sts.list_end     = (4'(list_pos_q + 4'd1) >= counts_q[cmd.list_sel]);
		sts.list_pos     = list_pos_q;
		sts.comment_last = (comment_q == 8'd1);
		sts.out_free     = !out_valid_q || !out_stall;
	end

	// control and storage registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_left_q <= 4'd0;
			coll_q      <= 8'd0;
			pend_q      <= 4'd0;
			list_pos_q  <= 4'd0;
			comment_q   <= 8'd0;
			prof_q      <= 2'd1;
			vfic_q      <= 5'd12;
			out_valid_q <= 1'b0;
			for (int i = 0; i < LIST_CNT; i++) begin
				counts_q[i] <= 4'd0;
			end
		end else begin
			// byte bookkeeping
			if (cmd.load) begin
				bits_left_q <= cmd.use_offset ? 4'(4'd8 - {1'b0, start_bit_offset}) : 4'd8;
			end else if (cmd.drop) begin
				bits_left_q <= 4'd0;
			end else if (cmd.step) begin
				bits_left_q <= 4'(bits_left_q - 4'd1);
			end

			// field collector
			if (cmd.clear) begin
				coll_q <= 8'd0;
				pend_q <= 4'd0;
			end else if (cmd.step) begin
				if (sts.field_done) begin
					coll_q <= 8'd0;
					pend_q <= 4'd0;
				end else begin
					coll_q <= coll_next;
					pend_q <= pend_next;
				end
			end

			// element counts
			if (cmd.clear) begin
				for (int i = 0; i < LIST_CNT; i++) begin
					counts_q[i] <= 4'd0;
				end
			end else if (cmd.count_wr) begin
				counts_q[cmd.count_sel] <= coll_next[3:0];
			end

			// list position
			if (cmd.clear || cmd.list_clr) begin
				list_pos_q <= 4'd0;
			end else if (cmd.list_adv) begin
				list_pos_q <= 4'(list_pos_q + 4'd1);
			end

			// comment bytes left
			if (cmd.clear) begin
				comment_q <= 8'd0;
			end else if (cmd.comment_ld) begin
				comment_q <= coll_next;
			end else if (cmd.comment_dec) begin
				comment_q <= 8'(comment_q - 8'd1);
			end

			// configuration writes
			if (cfg_wr_en) begin
				unique case (cfg_index)
					CFG_PROFILE:  prof_q <= cfg_data[1:0];
					CFG_FREQ_CNT: vfic_q <= cfg_data;
					default:      ;
				endcase
			end

			// output register
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			byte_q <= cmd.use_offset ? 8'(data_byte << start_bit_offset) : data_byte;
		end else if (cmd.step) begin
			byte_q <= {byte_q[6:0], 1'b0};
		end
		if (cmd.emit) begin
			res_q <= cmd.res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = res_q;

endmodule

>>> hdl/aacpcp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aacpcp_ctrl: field sequencer of the program config parser
// Walks element syntax one bit per cycle if the output is free; forms results.
// ----------------------------------------------------------------------------
module aacpcp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               start_element,
	input  aacpcp_pkg::sts_t   sts,
	output aacpcp_pkg::cmd_t   cmd
);
	import aacpcp_pkg::*;

	typedef enum logic [4:0] {
		PH_IDLE, PH_TAG, PH_OBJ, PH_SFI,
		PH_NFRONT, PH_NSIDE, PH_NBACK, PH_NLFE, PH_NASSOC, PH_NCC,
		PH_MONO_P, PH_MONO_N, PH_STEREO_P, PH_STEREO_N,
		PH_MATRIX_P, PH_MATRIX_V, PH_LIST, PH_CLEN, PH_COMMENT, PH_DONE
	} phase_t;

	phase_t     phase_q, phase_d;
	logic [2:0] list_sel_q, list_sel_d;
	logic       in_acc;
	logic [3:0] nl;
	logic [2:0] nl_from;

	function automatic res_t mk_res(input logic [4:0] code, input logic [3:0] idx,
	                                input logic [7:0] val, input logic pair,
	                                input logic [1:0] st, input logic lst);
		res_t r;
		r.code   = code;
		r.index  = idx;
		r.value  = val;
		r.pair   = pair;
		r.status = st;
		r.last   = lst;
		return r;
	endfunction

	function automatic logic [3:0] list_width(input logic [2:0] sel);
		logic [3:0] w;
		unique case (sel) inside
			LST_LFE, LST_ASSOC: w = 4'd4;
			default:            w = 4'd5;
		endcase
		return w;
	endfunction

	// first non-empty list at or after k: {found, list}
	function automatic logic [3:0] next_list(input logic [5:0] nz, input logic [2:0] k);
		logic [3:0] r;
		r = 4'd0;
		for (int i = LIST_CNT - 1; i >= 0; i--) begin
			if (3'(i) >= k && nz[i]) begin
				r = {1'b1, 3'(i)};
			end
		end
		return r;
	endfunction

	// busy while bits of a byte remain or the done result waits
	assign in_stall = sts.bit_avail || (phase_q == PH_DONE);
	assign in_acc   = in_valid && !in_stall;

	assign nl_from = (phase_q == PH_LIST) ? 3'(list_sel_q + 3'd1) : LST_FRONT;
	assign nl      = next_list(sts.count_nz, nl_from);

	// sequencer
	always_comb begin
		cmd        = '0;
		phase_d    = phase_q;
		list_sel_d = list_sel_q;
		cmd.list_sel = list_sel_q;

		// width of the field of this phase
		unique case (phase_q) inside
			PH_TAG, PH_SFI, PH_NFRONT, PH_NSIDE, PH_NBACK, PH_NCC,
			PH_MONO_N, PH_STEREO_N:            cmd.width = 4'd4;
			PH_OBJ, PH_NLFE:                   cmd.width = 4'd2;
			PH_NASSOC, PH_MATRIX_V:            cmd.width = 4'd3;
			PH_MONO_P, PH_STEREO_P, PH_MATRIX_P: cmd.width = 4'd1;
			PH_LIST:                           cmd.width = list_width(list_sel_q);
			PH_CLEN:                           cmd.width = 4'd8;
			default:                           cmd.width = 4'd1;
		endcase

		if (in_acc) begin
			// byte intake
			if (start_element) begin
				phase_d        = PH_TAG;
				list_sel_d     = LST_FRONT;
				cmd.clear      = 1'b1;
				cmd.load       = 1'b1;
				cmd.use_offset = 1'b1;
			end else if (phase_q != PH_IDLE) begin
				cmd.load = 1'b1;
			end
		end else if (phase_q == PH_DONE) begin
			if (sts.out_free) begin
				cmd.emit = 1'b1;
				cmd.res  = mk_res(FC_DONE, 4'd0, 8'd0, 1'b0, ST_OK, 1'b1);
				phase_d  = PH_IDLE;
			end
		end else if (sts.bit_avail && sts.out_free) begin
			if (phase_q == PH_COMMENT) begin
				// count off the loaded comment byte and drop its bits
				cmd.comment_dec = 1'b1;
				cmd.drop        = 1'b1;
				if (sts.comment_last) begin
					cmd.emit = 1'b1;
					cmd.res  = mk_res(FC_DONE, 4'd0, 8'd0, 1'b0, ST_OK, 1'b1);
					phase_d  = PH_IDLE;
				end
			end else if (phase_q == PH_IDLE) begin
				cmd.drop = 1'b1;
			end else begin
				cmd.step = 1'b1;
				if (sts.field_done) begin
					unique case (phase_q)
						PH_TAG: begin
							cmd.emit = 1'b1;
							cmd.res  = mk_res(FC_TAG, 4'd0, sts.value, 1'b0, ST_OK, 1'b0);
							phase_d  = PH_OBJ;
						end
						PH_OBJ: begin
							cmd.emit = 1'b1;
							if (sts.prof_ok) begin
								cmd.res = mk_res(FC_OBJ, 4'd0, sts.value, 1'b0, ST_OK, 1'b0);
								phase_d = PH_SFI;
							end else begin
								cmd.res  = mk_res(FC_OBJ, 4'd0, sts.value, 1'b0, ST_PROFILE,
								                  1'b1);
								cmd.drop = 1'b1;
								phase_d  = PH_IDLE;
							end
						end
						PH_SFI: begin
							cmd.emit = 1'b1;
							if (sts.sfi_ok) begin
								cmd.res = mk_res(FC_SFI, 4'd0, sts.value, 1'b0, ST_OK, 1'b0);
								phase_d = PH_NFRONT;
							end else begin
								cmd.res  = mk_res(FC_SFI, 4'd0, sts.value, 1'b0, ST_FREQ, 1'b1);
								cmd.drop = 1'b1;
								phase_d  = PH_IDLE;
							end
						end
						PH_NFRONT: begin
							cmd.emit      = 1'b1;
							cmd.res       = mk_res(FC_NFRONT, 4'd0, sts.value, 1'b0, ST_OK, 1'b0);
							cmd.count_wr  = 1'b1;
							cmd.count_sel = LST_FRONT;
							phase_d       = PH_NSIDE;
						end
						PH_NSIDE: begin
							cmd.emit      = 1'b1;
							cmd.res       = mk_res(FC_NSIDE, 4'd0, sts.value, 1'b0, ST_OK, 1'b0);
							cmd.count_wr  = 1'b1;
							cmd.count_sel = LST_SIDE;
							phase_d       = PH_NBACK;
						end
						PH_NBACK: begin
							cmd.emit      = 1'b1;
							cmd.res       = mk_res(FC_NBACK, 4'd0, sts.value, 1'b0, ST_OK, 1'b0);
							cmd.count_wr  = 1'b1;
							cmd.count_sel = LST_BACK;
							phase_d       = PH_NLFE;
						end
						PH_NLFE: begin
							cmd.emit      = 1'b1;
							cmd.res       = mk_res(FC_NLFE, 4'd0, sts.value, 1'b0, ST_OK, 1'b0);
							cmd.count_wr  = 1'b1;
							cmd.count_sel = LST_LFE;
							phase_d       = PH_NASSOC;
						end
						PH_NASSOC: begin
							cmd.emit      = 1'b1;
							cmd.res       = mk_res(FC_NASSOC, 4'd0, sts.value, 1'b0, ST_OK, 1'b0);
							cmd.count_wr  = 1'b1;
							cmd.count_sel = LST_ASSOC;
							phase_d       = PH_NCC;
						end
						PH_NCC: begin
							cmd.emit      = 1'b1;
							cmd.res       = mk_res(FC_NCC, 4'd0, sts.value, 1'b0, ST_OK, 1'b0);
							cmd.count_wr  = 1'b1;
							cmd.count_sel = LST_CC;
							phase_d       = PH_MONO_P;
						end
						PH_MONO_P: begin
							if (sts.value[0]) begin
								phase_d = PH_MONO_N;
							end else begin
								cmd.emit = 1'b1;
								cmd.res  = mk_res(FC_MONO, 4'd0, 8'd0, 1'b0, ST_OK, 1'b0);
								phase_d  = PH_STEREO_P;
							end
						end
						PH_MONO_N: begin
							cmd.emit = 1'b1;
							cmd.res  = mk_res(FC_MONO, 4'd0, sts.value, 1'b1, ST_OK, 1'b0);
							phase_d  = PH_STEREO_P;
						end
						PH_STEREO_P: begin
							if (sts.value[0]) begin
								phase_d = PH_STEREO_N;
							end else begin
								cmd.emit = 1'b1;
								cmd.res  = mk_res(FC_STEREO, 4'd0, 8'd0, 1'b0, ST_OK, 1'b0);
								phase_d  = PH_MATRIX_P;
							end
						end
						PH_STEREO_N: begin
							cmd.emit = 1'b1;
							cmd.res  = mk_res(FC_STEREO, 4'd0, sts.value, 1'b1, ST_OK, 1'b0);
							phase_d  = PH_MATRIX_P;
						end
						PH_MATRIX_P: begin
							if (sts.value[0]) begin
								phase_d = PH_MATRIX_V;
							end else begin
								cmd.emit     = 1'b1;
								cmd.res      = mk_res(FC_MATRIX, 4'd0, 8'd0, 1'b0, ST_OK, 1'b0);
								cmd.list_clr = 1'b1;
								if (nl[3]) begin
									phase_d    = PH_LIST;
									list_sel_d = nl[2:0];
								end else begin
									phase_d  = PH_CLEN;
									cmd.drop = 1'b1;
								end
							end
						end
						PH_MATRIX_V: begin
							// matrix index in bits 1:0, pseudo surround in bit 2
							cmd.emit     = 1'b1;
							cmd.res      = mk_res(FC_MATRIX, 4'd0,
							                      {5'd0, sts.value[0], sts.value[2:1]},
							                      1'b1, ST_OK, 1'b0);
							cmd.list_clr = 1'b1;
							if (nl[3]) begin
								phase_d    = PH_LIST;
								list_sel_d = nl[2:0];
							end else begin
								phase_d  = PH_CLEN;
								cmd.drop = 1'b1;
							end
						end
						PH_LIST: begin
							cmd.emit = 1'b1;
							cmd.res  = mk_res(5'(FC_LFRONT + {2'd0, list_sel_q}), sts.list_pos,
							                  {4'd0, sts.value[3:0]},
							                  (cmd.width == 4'd5) ? sts.value[4] : 1'b0,
							                  ST_OK, 1'b0);
							if (sts.list_end) begin
								cmd.list_clr = 1'b1;
								if (nl[3]) begin
									list_sel_d = nl[2:0];
								end else begin
									phase_d  = PH_CLEN;
									cmd.drop = 1'b1;
								end
							end else begin
								cmd.list_adv = 1'b1;
							end
						end
						PH_CLEN: begin
							cmd.emit = 1'b1;
							cmd.res  = mk_res(FC_CLEN, 4'd0, sts.value, 1'b0, ST_OK, 1'b0);
							cmd.drop = 1'b1;
							if (sts.value == 8'd0) begin
								phase_d = PH_DONE;
							end else begin
								cmd.comment_ld = 1'b1;
								phase_d        = PH_COMMENT;
							end
						end
						default: begin
							cmd.drop = 1'b1;
						end
					endcase
				end
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			list_sel_q <= LST_FRONT;
		end else begin
			phase_q    <= phase_d;
			list_sel_q <= list_sel_d;
		end
	end

	// a bit is consumed only when one is there and the output can take a result
	a_step_bit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> (sts.bit_avail && sts.out_free))
		else $error("bit step without a bit or with a full output");

	// a result is never written over one that waits
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.out_free)
		else $error("result emitted into a full output register");

	// byte intake and bit steps never overlap
	a_load_step: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.step))
		else $error("byte loaded while bits are being consumed");

	// the done result ends the element
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE && sts.out_free) |=> (phase_q == PH_IDLE))
		else $error("done result did not return to idle");

endmodule

>>> hdl/aac_program_config_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aac_program_config_parser: AAC program config element parser
// Bit-serial field sequencer with a separate datapath; one result per field.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------
//  in       | input     | in_valid / in_stall  | data_byte, start_element,
//           |           |                      | start_bit_offset
//  out      | output    | out_valid / out_stall| field_code, element_index,
//           |           |                      | field_value, pair_flag, status, last
//  cfg      | input     | cfg_wr_en            | cfg_index, cfg_data
//
//  A header byte is taken in, then walked one bit per cycle while the output is
//  free; on the first byte of an element the walk skips start_bit_offset bits,
//  and alignment or an error drops the rest of the byte. A comment byte is taken
//  in and then counted; a zero comment length leads to a separate done result.
//  A request is taken while the previous result still sits in the output
//  register; out_stall holds the sequencer before its next bit step.
//  Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module aac_program_config_parser (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       start_element,
	input  logic [2:0] start_bit_offset,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [4:0] field_code,
	output logic [3:0] element_index,
	output logic [7:0] field_value,
	output logic       pair_flag,
	output logic [1:0] status,
	output logic       last,
	input  logic       cfg_wr_en,
	input  logic       cfg_index,
	input  logic [4:0] cfg_data
);
	import aacpcp_pkg::*;

	cmd_t cmd;
	sts_t sts;
	res_t res;

	aacpcp_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.start_element (start_element),
		.sts           (sts),
		.cmd           (cmd)
	);

	aacpcp_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.data_byte        (data_byte),
		.start_bit_offset (start_bit_offset),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.out_res          (res)
	);

	// result fields
	assign field_code    = res.code;
	assign element_index = res.index;
	assign field_value   = res.value;
	assign pair_flag     = res.pair;
	assign status        = res.status;
	assign last          = res.last;

endmodule
